/* design/tcq_pkg.sv */
`default_nettype none

package tcq_pkg;

    // Fixed field widths of the request and response words.
    localparam int CMD_W    = 2;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAIN  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Configuration register map.
    localparam int                 APB_ADDR_W     = 2;
    localparam int                 APB_DATA_W     = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_STARVE_LIMIT = 2'd0;
    localparam logic [LIMIT_W-1:0] STARVE_LIMIT_RESET = 8'd10;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [TAG_W-1:0] op_tag;
        logic             at_safepoint;
    } req_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    out_tag;
        logic                out_class;
        logic                last;
        logic                urgent_pending;
    } rsp_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // request word taken this cycle
        logic load_tag;    // tag RAM read data is valid, load the result
        logic drain_step;  // pop the next urgent tag of a drain
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_result;   // the pending request gives at least one response
        logic fetch_needed; // the pending request will read a tag
        logic more_drain;   // a drain still has urgent tags to emit
    } dp_status_t;

endpackage

`default_nettype wire

/* design/two_class_queue_anti_starvation_unit.sv */
// An add, or a remove or drain that finds nothing, shows its result in the cycle after
// the request word is taken; a remove that returns a tag passes the fetch state first.
// A new request word is taken only after the last response word has been handed over; a drain
// passes the fetch state for each urgent tag, since each tag RAM has a registered read port.
// Reset (rst_n, asynchronous, active low) empties both queues, clears the starvation
// counter and sets starve_limit to 10; the tag RAM contents are left as they are.
`default_nettype none

module two_class_queue_anti_starvation_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Request channel.
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire tcq_pkg::req_word_t                 req_word,
    // Response channel.
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output tcq_pkg::rsp_word_t                      rsp_word,
    // Configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tcq_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [tcq_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [tcq_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready
);

    // The block works on one request word at a time. The controller sequences
    // the accept, the tag RAM fetch and the hand-over of each response word,
    // while the datapath holds the queue pointers, the starvation counter and
    // the response register that stands between the two channels.

    tcq_pkg::ctrl_cmd_t          ctrl_cmd;
    tcq_pkg::dp_status_t         dp_status;
    logic [tcq_pkg::LIMIT_W-1:0] starve_limit_reg;
    logic                        cfg_write;

    // The only register sits at address zero; writes elsewhere are dropped and
    // reads elsewhere return zero. Writes complete in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr == tcq_pkg::ADDR_STARVE_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            starve_limit_reg <= tcq_pkg::STARVE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            starve_limit_reg <= pwdata[tcq_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr == tcq_pkg::ADDR_STARVE_LIMIT)
                    ? tcq_pkg::APB_DATA_W'(starve_limit_reg) : '0;

    tcq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .dp_status(dp_status),
        .ctrl_cmd (ctrl_cmd)
    );

    // The datapath sees the request word directly; the controller's accept
    // command tells it when the word is really taken.
    tcq_datapath #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_word    (req_word),
        .starve_limit(starve_limit_reg),
        .ctrl_cmd    (ctrl_cmd),
        .dp_status   (dp_status),
        .rsp_word    (rsp_word)
    );

endmodule

`default_nettype wire

/* design/tcq_ram.sv */
`default_nettype none

module tcq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/tcq_ctrl.sv */
`default_nettype none

module tcq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    input  wire tcq_pkg::dp_status_t dp_status,
    output tcq_pkg::ctrl_cmd_t       ctrl_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next          = state_reg;
        ctrl_cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctrl_cmd.accept = 1'b1;
                    if (dp_status.has_result)
                    begin
                        state_next = dp_status.fetch_needed ? ST_FETCH : ST_EMIT;
                    end
                end
            end
            ST_FETCH:
            begin
                ctrl_cmd.load_tag = 1'b1;
                state_next        = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!rsp_stall)
                begin
                    if (dp_status.more_drain)
                    begin
                        ctrl_cmd.drain_step = 1'b1;
                        state_next          = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // An undefined command is taken in idle and the datapath ignores it, so the
    // controller only needs to leave idle for real commands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = (state_reg == ST_EMIT);

    a_fetch_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |=> state_reg == ST_EMIT)
        else $error("tag fetch not followed by a result");

    a_emit_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !rsp_stall && !dp_status.more_drain)
        |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after last word");

endmodule

`default_nettype wire

/* design/tcq_datapath.sv */
`default_nettype none

module tcq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tcq_pkg::req_word_t                req_word,
    input  wire logic [tcq_pkg::LIMIT_W-1:0]       starve_limit,
    input  wire tcq_pkg::ctrl_cmd_t                ctrl_cmd,
    output tcq_pkg::dp_status_t                    dp_status,
    output tcq_pkg::rsp_word_t                     rsp_word
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = AW + 1;
    localparam int SW = (TAG_BITS < tcq_pkg::TAG_W) ? TAG_BITS : tcq_pkg::TAG_W;

    localparam logic [AW-1:0] LAST_IDX  = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] DEPTH_P   = PW'(QUEUE_DEPTH);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] tail_addr(input logic [AW-1:0] head,
                                                input logic [FW-1:0] fill);
        logic [PW-1:0] pos;
        pos = PW'(head) + PW'(fill);
        return (pos >= DEPTH_P) ? AW'(pos - DEPTH_P) : AW'(pos);
    endfunction

    logic [AW-1:0]                u_head_reg, u_head_next;
    logic [FW-1:0]                u_fill_reg, u_fill_next;
    logic [AW-1:0]                n_head_reg, n_head_next;
    logic [FW-1:0]                n_fill_reg, n_fill_next;
    logic [tcq_pkg::LIMIT_W-1:0]  starve_reg, starve_next;
    logic                         sel_urgent_reg, sel_urgent_next;
    logic                         drain_reg, drain_next;
    logic [tcq_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [tcq_pkg::TAG_W-1:0]    res_tag_reg, res_tag_next;
    logic                         res_class_reg, res_class_next;
    logic                         res_last_reg, res_last_next;

    logic          u_ne, n_ne, u_full, n_full, prefer_u, take_u;
    logic          is_add, is_rem, is_drain;
    logic          push_u, push_n, pop_u, pop_n;
    logic [SW-1:0] u_rdata, n_rdata;

    assign u_ne     = (u_fill_reg != '0);
    assign n_ne     = (n_fill_reg != '0);
    assign u_full   = (u_fill_reg == FULL_FILL);
    assign n_full   = (n_fill_reg == FULL_FILL);
    assign prefer_u = (starve_reg < starve_limit);
    // Preferred queue first, the other one when the preferred one is empty.
    assign take_u   = prefer_u ? u_ne : !n_ne;

    assign is_add   = ctrl_cmd.accept && (req_word.cmd == tcq_pkg::CMD_ADD);
    assign is_rem   = ctrl_cmd.accept && (req_word.cmd == tcq_pkg::CMD_REMOVE);
    assign is_drain = ctrl_cmd.accept && (req_word.cmd == tcq_pkg::CMD_DRAIN);

    assign push_u = is_add && req_word.at_safepoint && !u_full;
    assign push_n = is_add && !req_word.at_safepoint && !n_full;
    assign pop_u  = (is_rem && take_u && u_ne) || (is_drain && u_ne) || ctrl_cmd.drain_step;
    assign pop_n  = is_rem && !take_u && n_ne;

    always_comb
    begin
        dp_status.has_result   = 1'b1;
        dp_status.fetch_needed = 1'b0;
        dp_status.more_drain   = drain_reg && u_ne;
        unique case (req_word.cmd)
            tcq_pkg::CMD_ADD:    dp_status.fetch_needed = 1'b0;
            tcq_pkg::CMD_REMOVE: dp_status.fetch_needed = u_ne || n_ne;
            tcq_pkg::CMD_DRAIN:  dp_status.fetch_needed = u_ne;
            default:             dp_status.has_result   = 1'b0;
        endcase
    end

    always_comb
    begin
        u_head_next = pop_u ? wrap_inc(u_head_reg) : u_head_reg;
        n_head_next = pop_n ? wrap_inc(n_head_reg) : n_head_reg;
        u_fill_next = u_fill_reg;
        n_fill_next = n_fill_reg;
        if (push_u)
        begin
            u_fill_next = u_fill_reg + FW'(1);
        end
        else if (pop_u)
        begin
            u_fill_next = u_fill_reg - FW'(1);
        end
        if (push_n)
        begin
            n_fill_next = n_fill_reg + FW'(1);
        end
        else if (pop_n)
        begin
            n_fill_next = n_fill_reg - FW'(1);
        end

        starve_next = starve_reg;
        if (is_rem)
        begin
            starve_next = prefer_u ? starve_reg + tcq_pkg::LIMIT_W'(1) : '0;
        end

        sel_urgent_next = sel_urgent_reg;
        drain_next      = drain_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_class_next  = res_class_reg;
        res_last_next   = res_last_reg;

        if (is_add)
        begin
            drain_next      = 1'b0;
            res_status_next = (req_word.at_safepoint ? u_full : n_full)
                              ? tcq_pkg::STATUS_FULL : tcq_pkg::STATUS_OK;
            res_tag_next    = '0;
            res_class_next  = 1'b0;
            res_last_next   = 1'b1;
        end
        else if (is_rem || is_drain)
        begin
            drain_next      = is_drain;
            sel_urgent_next = is_drain ? 1'b1 : take_u;
            res_status_next = tcq_pkg::STATUS_EMPTY;
            res_tag_next    = '0;
            res_class_next  = 1'b0;
            res_last_next   = 1'b1;
        end
        else if (ctrl_cmd.load_tag)
        begin
            res_status_next = tcq_pkg::STATUS_OK;
            res_tag_next    = sel_urgent_reg ? tcq_pkg::TAG_W'(u_rdata)
                                             : tcq_pkg::TAG_W'(n_rdata);
            res_class_next  = sel_urgent_reg;
            // The fill count already reflects the pop of this tag.
            res_last_next   = drain_reg ? !u_ne : 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_head_reg <= '0;
            u_fill_reg <= '0;
            n_head_reg <= '0;
            n_fill_reg <= '0;
            starve_reg <= '0;
            drain_reg  <= 1'b0;
        end
        else
        begin
            u_head_reg <= u_head_next;
            u_fill_reg <= u_fill_next;
            n_head_reg <= n_head_next;
            n_fill_reg <= n_fill_next;
            starve_reg <= starve_next;
            drain_reg  <= drain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_urgent_reg <= sel_urgent_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_class_reg  <= res_class_next;
        res_last_reg   <= res_last_next;
    end

    tcq_ram #(
        .WIDTH(SW),
        .DEPTH(QUEUE_DEPTH)
    ) u_urgent_ram (
        .clk    (clk),
        .wr_en  (push_u),
        .wr_addr(tail_addr(u_head_reg, u_fill_reg)),
        .wr_data(req_word.op_tag[SW-1:0]),
        .rd_en  (pop_u),
        .rd_addr(u_head_reg),
        .rd_data(u_rdata)
    );

    tcq_ram #(
        .WIDTH(SW),
        .DEPTH(QUEUE_DEPTH)
    ) u_normal_ram (
        .clk    (clk),
        .wr_en  (push_n),
        .wr_addr(tail_addr(n_head_reg, n_fill_reg)),
        .wr_data(req_word.op_tag[SW-1:0]),
        .rd_en  (pop_n),
        .rd_addr(n_head_reg),
        .rd_data(n_rdata)
    );

    assign rsp_word.status         = res_status_reg;
    assign rsp_word.out_tag        = res_tag_reg;
    assign rsp_word.out_class      = res_class_reg;
    assign rsp_word.last           = res_last_reg;
    assign rsp_word.urgent_pending = u_ne;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_u |-> u_ne) and (pop_n |-> n_ne))
        else $error("pop from an empty queue");

    a_load_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.load_tag |-> $past(pop_u || pop_n))
        else $error("tag loaded without a preceding RAM read");

endmodule

`default_nettype wire
